@@ hw/rtl/mlfq_pkg.sv @@
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared constants and operation codes of the scheduler arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfq_pkg;

    // 17.14 fixed point
    localparam int FRAC_BITS  = 14;
    localparam int FONE       = 1 << FRAC_BITS;
    localparam int DECAY_COEF = (59 * FONE) / 60;
    localparam int GAIN_COEF  = FONE / 60;
    localparam int SCALE_100  = 100;

    // priority divides recent cpu by 4 before rounding
    localparam int PRIO_SHIFT = FRAC_BITS + 2;

    // accumulator of the shared adder
    localparam int ACC_W = 48;

    // serial steps of the multiply and of the divide
    localparam int STEPS = FRAC_BITS;
    localparam int CNT_W = $clog2(STEPS);

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_LOAD_UPDATE = 3'd0;
    localparam logic [OP_W-1:0] OP_RECENT_CPU  = 3'd1;
    localparam logic [OP_W-1:0] OP_PRIORITY    = 3'd2;
    localparam logic [OP_W-1:0] OP_LOAD_X100   = 3'd3;
    localparam logic [OP_W-1:0] OP_RECENT_X100 = 3'd4;

    localparam int MAX_THREADS_DEF  = 64;
    localparam int TOP_PRIORITY_DEF = 63;

endpackage

`default_nettype wire

@@ hw/rtl/mlfq_load_cpu_priority_unit.sv @@
// ----------------------------------------------------------------------------
// mlfq_load_cpu_priority_unit
// Fixed-point load average, recent cpu and priority arithmetic of a
// multilevel feedback scheduler.
//
// The cmd channel (cmd_valid / cmd_stall) takes one item: an operation code
// with ready thread count, recent cpu and nice value. The res channel
// (res_valid / res_stall) returns exactly one value per item, in order.
// The serial multiplies, the divide, rounding, truncation and the final
// shift run on one shared 48-bit adder under a small sequencer: multiplies
// go shift-and-add one multiplier bit a cycle, the recent cpu coefficient
// is a restoring divide one quotient bit a cycle, and rounding, truncation
// and the final shift each have an adder state. Recent cpu divides first,
// x100 values and priority round, and all but unused codes truncate and
// shift. cmd_stall is high while an item is in work, so a new item is taken
// only after the last one is done. The result register lets the next item be
// taken while a finished value waits; a finished item that meets a still
// stalled result register waits in its last state until that one is taken.
// Reset clears the load average to zero and empties the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfq_load_cpu_priority_unit #(
    parameter int MAX_THREADS  = mlfq_pkg::MAX_THREADS_DEF,
    parameter int TOP_PRIORITY = mlfq_pkg::TOP_PRIORITY_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_stall,
    input  wire logic [mlfq_pkg::OP_W-1:0]   operation,
    input  wire logic [6:0]                  ready_threads,
    input  wire logic signed [31:0]          cpu_usage,
    input  wire logic signed [5:0]           niceness,
    output logic                             res_valid,
    input  wire logic                        res_stall,
    output logic signed [31:0]               value
);

    localparam int AW = mlfq_pkg::ACC_W;
    localparam int SW = mlfq_pkg::STEPS;
    localparam int CW = mlfq_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_RND,
        S_TRC,
        S_SHF,
        S_FIN
    } state_t;

    state_t                       state_reg, state_next;
    logic [mlfq_pkg::OP_W-1:0]    op_reg, op_next;
    logic                         wide_reg, wide_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic signed [AW-1:0]         acc_reg, acc_next;
    logic signed [AW-1:0]         mpl_reg, mpl_next;
    logic [SW-1:0]                mq_reg, mq_next;
    logic signed [AW-1:0]         div_reg, div_next;
    logic signed [AW-1:0]         add_reg, add_next;
    logic signed [5:0]            nice_reg, nice_next;
    logic signed [31:0]           load_reg, load_next;
    logic                         res_valid_reg, res_valid_next;
    logic signed [31:0]           value_reg, value_next;

    logic signed [AW-1:0] add_a, add_b, sum;
    logic                 add_sub;
    logic signed [AW-1:0] half, bias, shifted;
    logic signed [AW-1:0] twice_load;
    logic [6:0]           ready_sat;
    logic signed [31:0]   sat_val;
    logic signed [19:0]   prio_raw;
    logic signed [31:0]   prio_val;
    logic signed [31:0]   result;

    assign half    = wide_reg ? AW'(1) <<< (mlfq_pkg::PRIO_SHIFT - 1)
                              : AW'(1) <<< (mlfq_pkg::FRAC_BITS - 1);
    assign bias    = wide_reg ? (AW'(1) <<< mlfq_pkg::PRIO_SHIFT) - AW'(1)
                              : (AW'(1) <<< mlfq_pkg::FRAC_BITS) - AW'(1);
    assign shifted = wide_reg ? acc_reg >>> mlfq_pkg::PRIO_SHIFT
                              : acc_reg >>> mlfq_pkg::FRAC_BITS;

    // shared adder operand select
    always_comb
    begin
        add_a   = acc_reg;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            S_DIV:
            begin
                add_a   = acc_reg <<< 1;
                add_b   = div_reg;
                add_sub = 1'b1;
            end
            S_MUL:
            begin
                add_b = mpl_reg;
            end
            S_RND:
            begin
                add_b   = half;
                add_sub = acc_reg[AW-1];
            end
            S_TRC:
            begin
                add_b = acc_reg[AW-1] ? bias : '0;
            end
            S_SHF:
            begin
                add_a = shifted;
                add_b = add_reg;
            end
            default:
            begin
                add_b = '0;
            end
        endcase
    end

    assign sum = add_a + (add_b ^ {AW{add_sub}}) + AW'(add_sub);

    assign ready_sat = (32'(ready_threads) > 32'(MAX_THREADS)) ? 7'(MAX_THREADS)
                                                               : ready_threads;
    assign twice_load = AW'(load_reg) <<< 1;

    // saturate the accumulator to 32-bit signed
    always_comb
    begin
        if (acc_reg[AW-1:31] == '0 || acc_reg[AW-1:31] == '1)
        begin
            sat_val = acc_reg[31:0];
        end
        else if (acc_reg[AW-1])
        begin
            sat_val = 32'sh8000_0000;
        end
        else
        begin
            sat_val = 32'sh7fff_ffff;
        end
    end

    // priority from the rounded quarter of recent cpu, clamped
    always_comb
    begin
        prio_raw = 20'(TOP_PRIORITY) - $signed(acc_reg[19:0]) - (20'(nice_reg) <<< 1);
        if (prio_raw < 0)
        begin
            prio_val = '0;
        end
        else if (prio_raw > 20'(TOP_PRIORITY))
        begin
            prio_val = 32'(TOP_PRIORITY);
        end
        else
        begin
            prio_val = 32'(prio_raw);
        end
    end

    always_comb
    begin
        if (op_reg == mlfq_pkg::OP_PRIORITY)
        begin
            result = prio_val;
        end
        else if (op_reg == mlfq_pkg::OP_LOAD_UPDATE || op_reg == mlfq_pkg::OP_RECENT_CPU
                 || op_reg == mlfq_pkg::OP_LOAD_X100 || op_reg == mlfq_pkg::OP_RECENT_X100)
        begin
            result = sat_val;
        end
        else
        begin
            result = '0;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        wide_next      = wide_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        mpl_next       = mpl_reg;
        mq_next        = mq_reg;
        div_next       = div_reg;
        add_next       = add_reg;
        nice_next      = nice_reg;
        load_next      = load_reg;
        value_next     = value_reg;
        res_valid_next = res_valid_reg;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next   = operation;
                    nice_next = niceness;
                    wide_next = 1'b0;
                    add_next  = '0;
                    acc_next  = '0;
                    cnt_next  = CW'(SW - 1);
                    unique case (operation)
                        mlfq_pkg::OP_LOAD_UPDATE:
                        begin
                            mpl_next   = AW'(load_reg);
                            mq_next    = SW'(mlfq_pkg::DECAY_COEF);
                            add_next   = AW'(ready_sat) * AW'(mlfq_pkg::GAIN_COEF);
                            state_next = S_MUL;
                        end
                        mlfq_pkg::OP_RECENT_CPU:
                        begin
                            acc_next   = twice_load;
                            div_next   = twice_load + AW'(mlfq_pkg::FONE);
                            mpl_next   = AW'(cpu_usage);
                            mq_next    = '0;
                            add_next   = AW'(niceness) <<< mlfq_pkg::FRAC_BITS;
                            state_next = S_DIV;
                        end
                        mlfq_pkg::OP_PRIORITY:
                        begin
                            acc_next   = AW'(cpu_usage);
                            wide_next  = 1'b1;
                            state_next = S_RND;
                        end
                        mlfq_pkg::OP_LOAD_X100:
                        begin
                            mpl_next   = AW'(load_reg);
                            mq_next    = SW'(mlfq_pkg::SCALE_100);
                            state_next = S_MUL;
                        end
                        mlfq_pkg::OP_RECENT_X100:
                        begin
                            mpl_next   = AW'(cpu_usage);
                            mq_next    = SW'(mlfq_pkg::SCALE_100);
                            state_next = S_MUL;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                if (!sum[AW-1])
                begin
                    acc_next = sum;
                    mq_next  = {mq_reg[SW-2:0], 1'b1};
                end
                else
                begin
                    acc_next = acc_reg <<< 1;
                    mq_next  = {mq_reg[SW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    acc_next   = '0;
                    cnt_next   = CW'(SW - 1);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // shift-and-add, multiplier lsb first
                if (mq_reg[0])
                begin
                    acc_next = sum;
                end
                mpl_next = mpl_reg <<< 1;
                mq_next  = mq_reg >> 1;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    if (op_reg == mlfq_pkg::OP_LOAD_X100 || op_reg == mlfq_pkg::OP_RECENT_X100)
                    begin
                        state_next = S_RND;
                    end
                    else
                    begin
                        state_next = S_TRC;
                    end
                end
            end
            S_RND:
            begin
                acc_next   = sum;
                state_next = S_TRC;
            end
            S_TRC:
            begin
                acc_next   = sum;
                state_next = S_SHF;
            end
            S_SHF:
            begin
                acc_next   = sum;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    value_next     = result;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (op_reg == mlfq_pkg::OP_LOAD_UPDATE)
                    begin
                        load_next = sat_val;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= '0;
            wide_reg      <= 1'b0;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            mpl_reg       <= '0;
            mq_reg        <= '0;
            div_reg       <= '0;
            add_reg       <= '0;
            nice_reg      <= '0;
            load_reg      <= '0;
            res_valid_reg <= 1'b0;
            value_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            wide_reg      <= wide_next;
            cnt_reg       <= cnt_next;
            acc_reg       <= acc_next;
            mpl_reg       <= mpl_next;
            mq_reg        <= mq_next;
            div_reg       <= div_next;
            add_reg       <= add_next;
            nice_reg      <= nice_next;
            load_reg      <= load_next;
            res_valid_reg <= res_valid_next;
            value_reg     <= value_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign value     = value_reg;

endmodule

`default_nettype wire

@@ hw/rtl/mlfq_checker.sv @@
// ----------------------------------------------------------------------------
// mlfq_checker
// Port-level checks of the scheduler arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cmd_valid,
    input wire logic        cmd_stall,
    input wire logic        res_valid,
    input wire logic        res_stall,
    input wire logic [31:0] value
);

    // an accepted item makes the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command side ready right after accepting an item");

    // a result only shows up out of a busy phase
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(cmd_stall))
    else $error("result appeared without an item in work");

    // finishing an item always loads the result register
    a_finish_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(cmd_stall) |-> res_valid)
    else $error("item finished without a result");

    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(value))
    else $error("stalled result changed");

endmodule

bind mlfq_load_cpu_priority_unit mlfq_checker u_mlfq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .value     (value)
);

`default_nettype wire
